// ===== rtl/core/bfa_pkg.sv =====
package bfa_pkg;

   localparam int DEF_MAX_INODES      = 4096;
   localparam int DEF_MAX_DATA_BLOCKS = 65536;

   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   localparam int INODE_LIMIT_W = 13;
   localparam int DATA_LIMIT_W  = 17;
   localparam logic [INODE_LIMIT_W-1:0] INODE_LIMIT_RESET = 13'd4096;
   localparam logic [DATA_LIMIT_W-1:0]  DATA_LIMIT_RESET  = 17'd65536;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_INODE_LIMIT = 1'b0;
   localparam logic CSR_DATA_LIMIT  = 1'b1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic POOL_INODE = 1'b0;
   localparam logic POOL_BLOCK = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_FULL,
      STATUS_ALREADY_FREE,
      STATUS_RANGE
   } status_type;

   typedef struct packed {
      logic        op;
      logic        pool;
      logic [15:0] item_index;
   } req_type;

   typedef struct packed {
      logic [15:0] granted_index;
      status_type  status;
   } rsp_type;

endpackage

// ===== rtl/core/bfa_map_ram.sv =====
module bfa_map_ram #(
   parameter int ROWS   = 2,
   parameter int ADDR_W = 1
) (
   input  logic                      clock,
   input  logic [ADDR_W-1:0]         addr,
   input  logic                      we,
   input  logic [bfa_pkg::WORD_W-1:0] wdata,
   input  logic                      re,
   output logic [bfa_pkg::WORD_W-1:0] rdata
);
   import bfa_pkg::*;

   logic [WORD_W-1:0] mem_ff [ROWS];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/bfa_find_zero.sv =====
module bfa_find_zero (
   input  logic [bfa_pkg::WORD_W-1:0] word,
   input  logic [bfa_pkg::WORD_W-1:0] mask,
   output logic                       found,
   output logic [bfa_pkg::BIT_W-1:0]  pos
);
   import bfa_pkg::*;

   logic [WORD_W-1:0] cand;

   assign cand  = ~word & mask;
   assign found = |cand;

   // lowest free bit wins
   always_comb begin
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (cand[i]) begin
            pos = BIT_W'(i);
         end
      end
   end

endmodule

// ===== rtl/core/bfa_seq.sv =====
module bfa_seq #(
   parameter int MAX_INODES      = bfa_pkg::DEF_MAX_INODES,
   parameter int LIM_W           = 17,
   parameter int ROWS            = 2,
   parameter int ADDR_W          = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  bfa_pkg::req_type           req_data,
   input  logic [LIM_W-1:0]           inode_lim,
   input  logic [LIM_W-1:0]           block_lim,
   output logic                       rsp_valid,
   output bfa_pkg::rsp_type           rsp_data,
   output logic [ADDR_W-1:0]          ram_addr,
   output logic                       ram_we,
   output logic [bfa_pkg::WORD_W-1:0] ram_wdata,
   output logic                       ram_re,
   input  logic [bfa_pkg::WORD_W-1:0] ram_rdata
);
   import bfa_pkg::*;

   localparam int IROWS = (MAX_INODES + WORD_W - 1) / WORD_W;
   localparam int ROW_W = LIM_W - BIT_W;
   localparam int SUM_W = (ADDR_W > ROW_W ? ADDR_W : ROW_W) + 1;
   localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(ROWS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC_RD,
      ST_ALLOC_CHK,
      ST_FREE_RD,
      ST_FREE_CHK
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [LIM_W-1:0]  lim_ff;
   logic [LIM_W-1:0]  base_ff;
   logic [BIT_W-1:0]  bit_ff;
   logic              pool_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [SUM_W-1:0]  row_sum;
   logic [LIM_W-1:0]  rem;
   logic [LIM_W:0]    next_base;
   logic [LIM_W-1:0]  granted;
   logic [LIM_W-1:0]  sel_lim;
   logic [LIM_W-1:0]  idx_ext;
   logic [WORD_W-1:0] scan_mask;
   logic              scan_found;
   logic [BIT_W-1:0]  scan_pos;

   bfa_find_zero u_find_zero (
      .word  (ram_rdata),
      .mask  (scan_mask),
      .found (scan_found),
      .pos   (scan_pos)
   );

   assign row_sum = SUM_W'(base_ff[LIM_W-1:BIT_W])
                  + ((pool_ff == POOL_BLOCK) ? SUM_W'(IROWS) : SUM_W'(0));
   assign rem       = lim_ff - base_ff;
   assign scan_mask = (rem >= LIM_W'(WORD_W)) ? '1
                    : (WORD_W'(1) << rem[BIT_W-1:0]) - WORD_W'(1);
   assign next_base = {1'b0, base_ff} + (LIM_W + 1)'(WORD_W);
   assign granted   = base_ff + LIM_W'(scan_pos);
   assign sel_lim   = (req_data.pool == POOL_BLOCK) ? block_lim : inode_lim;
   assign idx_ext   = LIM_W'(req_data.item_index);

   assign ram_addr = (state_ff == ST_CLEAR) ? clr_ff : row_sum[ADDR_W-1:0];
   assign ram_re   = (state_ff == ST_ALLOC_RD) || (state_ff == ST_FREE_RD);

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
         end
         ST_ALLOC_CHK: begin
            ram_we    = scan_found;
            ram_wdata = ram_rdata | (WORD_W'(1) << scan_pos);
         end
         ST_FREE_CHK: begin
            ram_we    = ram_rdata[bit_ff];
            ram_wdata = ram_rdata & ~(WORD_W'(1) << bit_ff);
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               rsp_valid_ff <= 1'b0;
               clr_ff       <= clr_ff + ADDR_W'(1);
               if (clr_ff == LAST_ROW) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               rsp_valid_ff <= start && ((req_data.op == OP_ALLOC)
                                         ? (sel_lim == '0) : (idx_ext >= sel_lim));
               if (start) begin
                  pool_ff <= req_data.pool;
                  lim_ff  <= sel_lim;
                  bit_ff  <= req_data.item_index[BIT_W-1:0];
                  if (req_data.op == OP_ALLOC) begin
                     base_ff <= '0;
                     if (sel_lim == '0) begin
                        rsp_ff.granted_index <= '0;
                        rsp_ff.status        <= STATUS_FULL;
                     end else begin
                        state_ff <= ST_ALLOC_RD;
                     end
                  end else begin
                     base_ff <= {idx_ext[LIM_W-1:BIT_W], BIT_W'(0)};
                     if (idx_ext >= sel_lim) begin
                        rsp_ff.granted_index <= '0;
                        rsp_ff.status        <= STATUS_RANGE;
                     end else begin
                        state_ff <= ST_FREE_RD;
                     end
                  end
               end
            end
            ST_ALLOC_RD: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_ALLOC_CHK;
            end
            ST_ALLOC_CHK: begin
               rsp_valid_ff <= scan_found || (next_base >= {1'b0, lim_ff});
               if (scan_found) begin
                  rsp_ff.granted_index <= granted[15:0];
                  rsp_ff.status        <= STATUS_OK;
                  state_ff             <= ST_IDLE;
               end else if (next_base >= {1'b0, lim_ff}) begin
                  rsp_ff.granted_index <= '0;
                  rsp_ff.status        <= STATUS_FULL;
                  state_ff             <= ST_IDLE;
               end else begin
                  base_ff  <= next_base[LIM_W-1:0];
                  state_ff <= ST_ALLOC_RD;
               end
            end
            ST_FREE_RD: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_FREE_CHK;
            end
            ST_FREE_CHK: begin
               rsp_valid_ff         <= 1'b1;
               rsp_ff.granted_index <= '0;
               rsp_ff.status        <= ram_rdata[bit_ff] ? STATUS_OK : STATUS_ALREADY_FREE;
               state_ff             <= ST_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/bitmap_first_free_allocator_core.sv =====
// First-fit allocator over two occupancy bitmaps (inodes, data blocks), kept
// as 32-bit words in one single-port RAM. After reset the block clears the RAM
// one word per cycle, all ceil(MAX_INODES/32) + ceil(MAX_DATA_BLOCKS/32) words
// (2176 by default), with busy high; limit registers can be written meanwhile.
// A request is taken when start is high and busy low. A free reads the word,
// then checks it and writes it back. An allocate reads and then tests one
// word at a time, up to the word holding the first free entry, at most
// ceil(limit/32) words. A free out of range or an allocate with a zero limit
// answers in the next cycle. The result is shown for one cycle with rsp_valid;
// it cannot be stalled, and the next request may be taken in the same cycle.
module bitmap_first_free_allocator_core #(
   parameter int MAX_INODES      = bfa_pkg::DEF_MAX_INODES,
   parameter int MAX_DATA_BLOCKS = bfa_pkg::DEF_MAX_DATA_BLOCKS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  bfa_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output bfa_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bfa_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bfa_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bfa_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import bfa_pkg::*;

   localparam int IW    = $clog2(MAX_INODES + 1);
   localparam int DW    = $clog2(MAX_DATA_BLOCKS + 1);
   localparam int MW    = (IW > DW) ? IW : DW;
   localparam int LIM_W = (MW > DATA_LIMIT_W) ? MW : DATA_LIMIT_W;
   localparam int ROWS  = (MAX_INODES + WORD_W - 1) / WORD_W
                        + (MAX_DATA_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int ADDR_W = $clog2(ROWS);

   logic [INODE_LIMIT_W-1:0] inode_limit_ff;
   logic [DATA_LIMIT_W-1:0]  data_limit_ff;
   logic                     csr_write;
   logic [LIM_W-1:0]         inode_lim;
   logic [LIM_W-1:0]         block_lim;

   logic [ADDR_W-1:0]        ram_addr;
   logic                     ram_we;
   logic [WORD_W-1:0]        ram_wdata;
   logic                     ram_re;
   logic [WORD_W-1:0]        ram_rdata;

   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inode_limit_ff <= INODE_LIMIT_RESET;
         data_limit_ff  <= DATA_LIMIT_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            CSR_INODE_LIMIT: inode_limit_ff <= pwdata[INODE_LIMIT_W-1:0];
            CSR_DATA_LIMIT:  data_limit_ff  <= pwdata[DATA_LIMIT_W-1:0];
            default: begin
               inode_limit_ff <= inode_limit_ff;
            end
         endcase
      end
   end

   assign prdata = (paddr[2] == CSR_DATA_LIMIT) ? CSR_DATA_W'(data_limit_ff)
                                                 : CSR_DATA_W'(inode_limit_ff);

   // limits saturate at the map depth
   assign inode_lim = (LIM_W'(inode_limit_ff) > LIM_W'(MAX_INODES))
                    ? LIM_W'(MAX_INODES) : LIM_W'(inode_limit_ff);
   assign block_lim = (LIM_W'(data_limit_ff) > LIM_W'(MAX_DATA_BLOCKS))
                    ? LIM_W'(MAX_DATA_BLOCKS) : LIM_W'(data_limit_ff);

   bfa_map_ram #(
      .ROWS   (ROWS),
      .ADDR_W (ADDR_W)
   ) u_map_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .re    (ram_re),
      .rdata (ram_rdata)
   );

   bfa_seq #(
      .MAX_INODES      (MAX_INODES),
      .LIM_W           (LIM_W),
      .ROWS            (ROWS),
      .ADDR_W          (ADDR_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .inode_lim (inode_lim),
      .block_lim (block_lim),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ram_addr  (ram_addr),
      .ram_we    (ram_we),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_rdata (ram_rdata)
   );

endmodule

// ===== rtl/core/bfa_checker.sv =====
module bfa_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input bfa_pkg::rsp_type rsp_data
);
   import bfa_pkg::*;

   // clear pass always follows reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   // a result needs an accepted request or work in flight
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result without request");

   a_fail_zero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> (rsp_data.granted_index == '0))
      else $error("nonzero index on failed request");

   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !rsp_valid)
      else $error("result while idle");

endmodule

bind bitmap_first_free_allocator_core bfa_checker u_bfa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
